[rtl/cac_pkg.sv]
package cac_pkg;

	localparam int DW    = 16;
	localparam int FW    = 12;
	localparam int STEPS = 31;
	localparam int QBITS = 17;
	localparam int RTBIT = 16;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_POL = 3'd4;

	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

	localparam logic [31:0] ATAN_TAB [STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001
	};

	typedef struct packed {
		logic               vld;
		logic [2:0]         func;
		logic               dz;
		logic signed [20:0] dre;
		logic signed [20:0] dim;
		logic               nre_neg;
		logic               nim_neg;
		logic               ovre;
		logic               ovim;
		logic [48:0]        rre;
		logic [48:0]        rim;
		logic [31:0]        den;
		logic [16:0]        qre;
		logic [16:0]        qim;
		logic [31:0]        sq_n;
		logic [31:0]        sq_res;
		logic signed [41:0] cx;
		logic signed [41:0] cy;
		logic signed [34:0] cz;
		logic               czero;
	} cac_item_t;

	typedef struct packed {
		logic [15:0] val;
		logic        sat;
	} cac_clip_t;

	function automatic cac_clip_t clip16(input logic signed [35:0] v);
		cac_clip_t r;
		r.sat = 1'b0;
		r.val = v[15:0];
		if (v > 36'sd32767) begin
			r.sat = 1'b1;
			r.val = 16'h7fff;
		end else if (v < -36'sd32768) begin
			r.sat = 1'b1;
			r.val = 16'h8000;
		end
		return r;
	endfunction

endpackage

[rtl/complex_arithmetic_unit.sv]
// pipeline from input transaction to result: two setup stages, 31 rotation/division/root
// cells, one output register
// throughput: one transaction per cycle, set by the cell row advancing every cycle that en is high
// the whole row holds while a result waits on m_tready
// arst_n clears all valid flags and the cell row at once, operand and output data are not reset
module complex_arithmetic_unit import cac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // res_re, res_im
	output logic [1:0]  m_tuser   // saturated, div_zero
);

	cac_item_t          chain [STEPS+1];
	cac_item_t          l;
	logic               en;
	logic               out_vld_q;
	logic [31:0]        data_q;
	logic [1:0]         user_q;
	logic signed [35:0] vre, vim;
	logic [16:0]        qr, qi;
	logic [31:0]        root;
	logic [34:0]        zm;
	logic [16:0]        zr;
	cac_clip_t          cre, cim;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	cac_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.func   (s_tuser),
		.a_re   (s_tdata[15:0]),
		.a_im   (s_tdata[31:16]),
		.b_re   (s_tdata[47:32]),
		.b_im   (s_tdata[63:48]),
		.item   (chain[0])
	);

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		cac_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(g)),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	assign l = chain[STEPS];

	always_comb begin
		vre  = '0;
		vim  = '0;
		qr   = l.ovre ? 17'h10000 : l.qre;
		qi   = l.ovim ? 17'h10000 : l.qim;
		root = (l.sq_n > l.sq_res) ? l.sq_res + 32'd1 : l.sq_res;
		zm   = l.cz[34] ? 35'(-l.cz) : 35'(l.cz);
		zr   = 17'((zm + 35'h20000) >> 18);
		case (l.func)
			FN_ADD, FN_SUB, FN_MUL: begin
				vre = 36'(l.dre);
				vim = 36'(l.dim);
			end
			FN_DIV: begin
				if (!l.dz) begin
					vre = l.nre_neg ? -36'(qr) : 36'(qr);
					vim = l.nim_neg ? -36'(qi) : 36'(qi);
				end
			end
			FN_POL: begin
				vre = 36'(root);
				if (!l.czero) begin
					vim = l.cz[34] ? -36'(zr) : 36'(zr);
				end
			end
			default: begin
				vre = '0;
				vim = '0;
			end
		endcase
		cre = clip16(vre);
		cim = clip16(vim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= l.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {cim.val, cre.val};
			user_q <= {l.dz, cre.sat | cim.sat};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 32'd0 && !m_tuser[0])
		else $error("div_zero result not zero");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000
			|| m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000)
		else $error("saturated flag without clipped part");

endmodule

[rtl/cac_front.sv]
module cac_front import cac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [2:0]       func,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output cac_item_t        item
);

	logic               vld_s1;
	logic [2:0]         func_s1;
	logic signed [15:0] ar_s1, ai_s1;
	logic signed [16:0] sre_s1, sim_s1;
	logic signed [31:0] prr_s1, pii_s1, pri_s1, pir_s1, paa_s1, pbb_s1, pcc_s1, pdd_s1;
	cac_item_t          item_s2;
	cac_item_t          nx;

	logic signed [33:0] mre, mim, nre, nim;
	logic [33:0]        mre_m, mim_m;
	logic [21:0]        rre_m, rim_m;
	logic [32:0]        nre_m, nim_m;
	logic signed [16:0] xa, ya;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			sre_s1  <= (func == FN_SUB) ? 17'(a_re) - 17'(b_re) : 17'(a_re) + 17'(b_re);
			sim_s1  <= (func == FN_SUB) ? 17'(a_im) - 17'(b_im) : 17'(a_im) + 17'(b_im);
			prr_s1  <= a_re * b_re;
			pii_s1  <= a_im * b_im;
			pri_s1  <= a_re * b_im;
			pir_s1  <= a_im * b_re;
			paa_s1  <= a_re * a_re;
			pbb_s1  <= a_im * a_im;
			pcc_s1  <= b_re * b_re;
			pdd_s1  <= b_im * b_im;
		end
	end

	always_comb begin
		nx      = '0;
		nx.vld  = vld_s1;
		nx.func = func_s1;
		mre = 34'(prr_s1) - 34'(pii_s1);
		mim = 34'(pri_s1) + 34'(pir_s1);
		nre = 34'(prr_s1) + 34'(pii_s1);
		nim = 34'(pir_s1) - 34'(pri_s1);
		// multiply rounding, half away from zero
		mre_m = mre[33] ? 34'(-mre) : 34'(mre);
		mim_m = mim[33] ? 34'(-mim) : 34'(mim);
		rre_m = 22'((mre_m + 34'd2048) >> FW);
		rim_m = 22'((mim_m + 34'd2048) >> FW);
		if (func_s1 == FN_MUL) begin
			nx.dre = mre[33] ? 21'(-$signed(rre_m)) : 21'(rre_m);
			nx.dim = mim[33] ? 21'(-$signed(rim_m)) : 21'(rim_m);
		end else if (func_s1 == FN_ADD || func_s1 == FN_SUB) begin
			nx.dre = 21'(sre_s1);
			nx.dim = 21'(sim_s1);
		end
		// divide setup
		nx.den     = 32'(pcc_s1) + 32'(pdd_s1);
		nx.dz      = (func_s1 == FN_DIV) && (nx.den == 32'd0);
		nx.nre_neg = nre[33];
		nx.nim_neg = nim[33];
		nre_m      = nre[33] ? 33'(-nre) : 33'(nre);
		nim_m      = nim[33] ? 33'(-nim) : 33'(nim);
		nx.ovre    = {4'b0, nre_m} >= {nx.den, 5'b0};
		nx.ovim    = {4'b0, nim_m} >= {nx.den, 5'b0};
		nx.rre     = {4'b0, nre_m, 12'b0};
		nx.rim     = {4'b0, nim_m, 12'b0};
		// root setup
		nx.sq_n    = 32'(paa_s1) + 32'(pbb_s1);
		// vectoring setup, left half plane turned by pi
		xa = ar_s1[15] ? -17'(ar_s1) : 17'(ar_s1);
		ya = ar_s1[15] ? -17'(ai_s1) : 17'(ai_s1);
		nx.cx = 42'(xa) <<< 24;
		nx.cy = 42'(ya) <<< 24;
		nx.cz = ar_s1[15] ? (ai_s1[15] ? -PI_Q30 : PI_Q30) : 35'sd0;
		nx.czero = (ar_s1 == 16'sd0) && (ai_s1 == 16'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (en) begin
			item_s2 <= nx;
		end
	end

	assign item = item_s2;

endmodule

[rtl/cac_cell.sv]
module cac_cell import cac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic [4:0] step,
	input  cac_item_t d,
	output cac_item_t q
);

	cac_item_t          n;
	cac_item_t          item_q;
	logic [4:0]         k;
	logic [48:0]        dsh;
	logic [4:0]         bsh;
	logic [31:0]        sbit;
	logic [32:0]        trial;
	logic signed [41:0] dx, dy;
	logic signed [34:0] at;

	always_comb begin
		n     = d;
		k     = 5'd16 - step;
		dsh   = {17'b0, d.den} << k;
		bsh   = 5'd30 - {step[3:0], 1'b0};
		sbit  = 32'd1 << bsh;
		trial = {1'b0, d.sq_res} + {1'b0, sbit};
		dx    = d.cy >>> step;
		dy    = d.cx >>> step;
		at    = 35'(ATAN_TAB[step]);
		// restoring division, one quotient bit
		if (step < 5'd17) begin
			if (d.rre >= dsh) begin
				n.rre = d.rre - dsh;
				n.qre = d.qre | (17'd1 << k);
			end
			if (d.rim >= dsh) begin
				n.rim = d.rim - dsh;
				n.qim = d.qim | (17'd1 << k);
			end
		end
		// square root, one digit
		if (step < 5'd16) begin
			if ({1'b0, d.sq_n} >= trial) begin
				n.sq_n   = d.sq_n - trial[31:0];
				n.sq_res = (d.sq_res >> 1) + sbit;
			end else begin
				n.sq_res = d.sq_res >> 1;
			end
		end
		// vectoring rotation
		if (d.cy > 42'sd0) begin
			n.cx = d.cx + dx;
			n.cy = d.cy - dy;
			n.cz = d.cz + at;
		end else begin
			n.cx = d.cx - dx;
			n.cy = d.cy + dy;
			n.cz = d.cz - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (en) begin
			item_q <= n;
		end
	end

	assign q = item_q;

endmodule
